FILE: hdl/utd_pkg.sv
package utd_pkg;

  localparam int unsigned UNIT_W = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PAYLOAD_W = 6;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  localparam logic [2:0] LEAD3_PREFIX = 3'b111;
  localparam logic [1:0] LEAD2_PREFIX = 2'b11;

  typedef struct packed {
    logic              valid;
    logic [UNIT_W-1:0] code_unit;
    logic              truncated;
  } utd_result_t;

endpackage

FILE: hdl/utd_byte_if.sv
interface utd_byte_if;
  import utd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

FILE: hdl/utd_unit_if.sv
interface utd_unit_if;
  import utd_pkg::*;

  logic              valid;
  logic              ready;
  logic [UNIT_W-1:0] code_unit;
  logic              truncated;

  modport source (output valid, output code_unit, output truncated, input ready);
  modport sink (input valid, input code_unit, input truncated, output ready);
endinterface

FILE: hdl/utf8_to_ucs2_decoder.sv
// Lax UTF-8 to UCS-2 decoder. Takes one byte per cycle on text and gives one
// 16-bit code unit on chars for every ASCII byte and every completed two- or
// three-byte sequence; continuation bytes are not checked and stray ones in lead
// position are dropped. A byte flagged end_of_text inside a sequence flushes the
// partial value with truncated set. The decode is a single step on the sequence
// state, and results go through an output register backed by a one-entry skid
// register, so text keeps flowing at one byte per cycle as long as chars is
// taken.
module utf8_to_ucs2_decoder
  import utd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  utd_byte_if.sink   text,
  utd_unit_if.source chars
);

  logic [1:0]        pending;
  logic [1:0]        pending_next;
  logic [UNIT_W-1:0] partial;
  logic [UNIT_W-1:0] partial_next;
  utd_result_t       result;

  logic              out_valid;
  logic [UNIT_W-1:0] out_unit;
  logic              out_trunc;
  logic              skid_valid;
  logic [UNIT_W-1:0] skid_unit;
  logic              skid_trunc;

  logic in_xfer;
  logic out_xfer;
  logic fires;

  utd_decode u_decode (
    .pending      (pending),
    .partial      (partial),
    .in_byte      (text.in_byte),
    .end_of_text  (text.end_of_text),
    .pending_next (pending_next),
    .partial_next (partial_next),
    .result       (result)
  );

  assign text.ready      = !skid_valid;
  assign in_xfer         = text.valid && text.ready;
  assign out_xfer        = out_valid && chars.ready;
  assign fires           = in_xfer && result.valid;
  assign chars.valid     = out_valid;
  assign chars.code_unit = out_unit;
  assign chars.truncated = out_trunc;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= PEND_NONE;
      partial <= '0;
    end else if (in_xfer) begin
      pending <= pending_next;
      partial <= partial_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_xfer) begin
        out_unit   <= skid_unit;
        out_trunc  <= skid_trunc;
        skid_valid <= 1'b0;
      end
    end else if (fires) begin
      if (!out_valid || out_xfer) begin
        out_valid <= 1'b1;
        out_unit  <= result.code_unit;
        out_trunc <= result.truncated;
      end else begin
        skid_valid <= 1'b1;
        skid_unit  <= result.code_unit;
        skid_trunc <= result.truncated;
      end
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: hdl/utd_decode.sv
module utd_decode
  import utd_pkg::*;
(
  input  logic [1:0]        pending,
  input  logic [UNIT_W-1:0] partial,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              end_of_text,
  output logic [1:0]        pending_next,
  output logic [UNIT_W-1:0] partial_next,
  output utd_result_t       result
);

  logic done;

  always_comb begin
    result       = '0;
    pending_next = pending;
    partial_next = partial;
    done         = 1'b0;

    if (pending != PEND_NONE) begin
      if (pending >= PEND_TWO) begin
        partial_next = partial | {4'd0, in_byte[PAYLOAD_W-1:0], 6'd0};
        pending_next = PEND_ONE;
      end else begin
        result.valid     = 1'b1;
        result.code_unit = partial | {10'd0, in_byte[PAYLOAD_W-1:0]};
        result.truncated = 1'b0;
        partial_next     = '0;
        pending_next     = PEND_NONE;
        done             = 1'b1;
      end
    end else if (!in_byte[BYTE_W-1]) begin
      result.valid     = 1'b1;
      result.code_unit = {8'd0, in_byte};
      result.truncated = 1'b0;
      done             = 1'b1;
    end else if (in_byte[7:5] == LEAD3_PREFIX) begin
      partial_next = {in_byte[3:0], 12'd0};
      pending_next = PEND_TWO;
    end else if (in_byte[7:6] == LEAD2_PREFIX) begin
      partial_next = {5'd0, in_byte[4:0], 6'd0};
      pending_next = PEND_ONE;
    end else begin
      // stray continuation byte
      done = 1'b1;
    end

    if (!done && end_of_text) begin
      result.valid     = 1'b1;
      result.code_unit = partial_next;
      result.truncated = 1'b1;
      partial_next     = '0;
      pending_next     = PEND_NONE;
    end
  end

endmodule

FILE: hdl/utd_checker.sv
module utd_checker
  import utd_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [UNIT_W-1:0] code_unit,
  input logic              truncated
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_unit) && $stable(truncated))
    else $error("stalled result changed");

  a_trunc_low_bits: assert property (@(posedge clk) disable iff (rst)
    out_valid && truncated |-> code_unit[5:0] == 6'd0)
    else $error("truncated unit has continuation bits in low field");

  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    !in_ready && !$past(rst) |-> $past(out_valid && !out_ready))
    else $error("input stalled without output backpressure");

endmodule

bind utf8_to_ucs2_decoder utd_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (text.ready),
  .out_valid (chars.valid),
  .out_ready (chars.ready),
  .code_unit (chars.code_unit),
  .truncated (chars.truncated)
);
